### rtl/fbpe_pkg.sv
// ----------------------------------------------------------------------------
// fbpe_pkg
// Shared types and constants for the monochrome frame buffer pixel engine.
// ----------------------------------------------------------------------------
package fbpe_pkg;

    localparam int DISPLAY_HEIGHT = 32;
    localparam int PANEL_WIDTH    = 64;
    localparam int ROW_BYTES      = 8;
    localparam int STORE_BYTES    = DISPLAY_HEIGHT * ROW_BYTES;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int ROW_W          = ADDR_W - 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_ORIGIN_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_ORIGIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT   = 3'd5;

    // ink codes; the unused fourth code draws as on
    localparam logic [1:0] INK_OFF    = 2'd0;
    localparam logic [1:0] INK_ON     = 2'd1;
    localparam logic [1:0] INK_TOGGLE = 2'd2;

    typedef enum logic [1:0] {
        MODE_DRAW       = 2'd0,
        MODE_READ_PIXEL = 2'd1,
        MODE_READ_BYTE  = 2'd2,
        MODE_CLEAR      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_ACCESS,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [7:0]  x_coord;
        logic signed [7:0]  y_coord;
        logic [1:0]         ink;
        logic [7:0]         byte_index;
    } pixel_in_t;

    typedef struct packed {
        logic       pixel_bit;
        logic [7:0] byte_value;
        logic       written;
    } pixel_out_t;

    typedef struct packed {
        logic [1:0]        rotation;
        logic              invert_pixels;
        logic signed [6:0] box_origin_x;
        logic signed [6:0] box_origin_y;
        logic [6:0]        box_width;
        logic [6:0]        box_height;
    } cfg_t;

    // result of the coordinate path: store byte, bit within it, and clip pass
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] idx;
        logic [2:0]        bit_sel;
    } loc_t;

endpackage

### rtl/fbpe_locator.sv
// ----------------------------------------------------------------------------
// fbpe_locator
// Box clip, origin offset, screen clip and rotation of a logical point into
// a store byte address and bit number.
// ----------------------------------------------------------------------------
module fbpe_locator (
    input  fbpe_pkg::pixel_in_t item,
    input  fbpe_pkg::cfg_t      cfg,
    output fbpe_pkg::loc_t      loc
);
    import fbpe_pkg::*;

    localparam logic [5:0] H_LAST = 6'(DISPLAY_HEIGHT - 1);

    logic              is_draw;
    logic signed [8:0] xe;
    logic signed [8:0] ye;
    logic signed [8:0] sx;
    logic signed [8:0] sy;
    logic              box_ok;
    logic [8:0]        scr_w;
    logic [8:0]        scr_h;
    logic              on_scr;
    logic [5:0]        lx;
    logic [5:0]        ly;
    logic [5:0]        px;
    logic [5:0]        py;

    assign is_draw = (item.mode == MODE_DRAW);
    assign xe      = {item.x_coord[7], item.x_coord};
    assign ye      = {item.y_coord[7], item.y_coord};

    // box clip is one-sided; read pixel ignores the box and the origin
    always_comb
    begin
        box_ok = 1'b1;
        if (is_draw)
        begin
            if (cfg.box_width != 7'd0 && !(xe < $signed({2'b00, cfg.box_width})))
                box_ok = 1'b0;
            if (cfg.box_height != 7'd0 && !(ye < $signed({2'b00, cfg.box_height})))
                box_ok = 1'b0;
        end
    end

    assign sx = is_draw ? xe + {{2{cfg.box_origin_x[6]}}, cfg.box_origin_x} : xe;
    assign sy = is_draw ? ye + {{2{cfg.box_origin_y[6]}}, cfg.box_origin_y} : ye;

    // logical screen is transposed for odd rotations
    assign scr_w  = cfg.rotation[0] ? 9'(DISPLAY_HEIGHT) : 9'(PANEL_WIDTH);
    assign scr_h  = cfg.rotation[0] ? 9'(PANEL_WIDTH) : 9'(DISPLAY_HEIGHT);
    assign on_scr = !sx[8] && !sy[8] && ($unsigned(sx) < scr_w) && ($unsigned(sy) < scr_h);

    assign lx = sx[5:0];
    assign ly = sy[5:0];

    // 63 - v is ~v in six bits
    always_comb
    begin
        unique case (cfg.rotation)
            2'd0:
            begin
                px = lx;
                py = ly;
            end
            2'd1:
            begin
                px = ~ly;
                py = lx;
            end
            2'd2:
            begin
                px = ~lx;
                py = H_LAST - ly;
            end
            default:
            begin
                px = ly;
                py = H_LAST - lx;
            end
        endcase
    end

    assign loc.hit     = box_ok && on_scr;
    assign loc.idx     = {py[ROW_W-1:0], ~px[5:3]};
    assign loc.bit_sel = px[2:0];

endmodule

### rtl/fbpe_frame_ram.sv
// ----------------------------------------------------------------------------
// fbpe_frame_ram
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbpe_frame_ram (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [fbpe_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                  rd_data,
    input  logic                        wr_en,
    input  logic [fbpe_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                  wr_data
);
    import fbpe_pkg::*;

    logic [7:0] mem [STORE_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

### rtl/mono_framebuffer_pixel_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_engine
// 1 bpp frame store with clipped, rotated pixel draw, pixel and byte read,
// and store clear.
// ----------------------------------------------------------------------------
//  channel | signals                      | transfer when
//  --------+------------------------------+------------------------------
//  in      | in_valid in_ready in_data    | in_valid && in_ready
//  out     | out_valid out_ready out_data | out_valid && out_ready
//  cfg     | cfg_wr_en cfg_index cfg_data | cfg_wr_en
//
//  Draw, read pixel, read byte: the store is read when the item is taken in
//  IDLE, then modify/write back and result load happen in ACCESS; no new
//  item is taken until IDLE. Clear: one byte zeroed per cycle through the
//  whole store, then the result load. After reset the store is wiped with
//  in_ready low; cfg writes are taken throughout. A result waiting in the
//  output register does not block the next transfer in; the engine only
//  stalls in its write-back cycle if that register is full and not read.
// ----------------------------------------------------------------------------
module mono_framebuffer_pixel_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  fbpe_pkg::pixel_in_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output fbpe_pkg::pixel_out_t            out_data,
    input  logic                            cfg_wr_en,
    input  logic [fbpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbpe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fbpe_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    state_t            state_reg;
    state_t            state_next;
    cfg_t              cfg_reg;
    pixel_in_t         item_reg;
    loc_t              loc_reg;
    logic [ADDR_W-1:0] cursor_reg;
    logic [ADDR_W-1:0] cursor_next;
    logic              out_valid_reg;
    pixel_out_t        out_reg;

    loc_t              loc;
    logic              in_xfer;
    logic              out_free;
    logic              cursor_last;
    logic              out_load;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              cur_bit;
    logic              new_bit;
    logic [7:0]        mod_byte;
    logic              byte_ok;
    pixel_out_t        result;

    fbpe_locator u_locator (
        .item (in_data),
        .cfg  (cfg_reg),
        .loc  (loc)
    );

    fbpe_frame_ram u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign in_xfer     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign cursor_last = (cursor_reg == LAST_ADDR);
    assign rd_addr     = (in_data.mode == MODE_READ_BYTE) ? ADDR_W'(in_data.byte_index) : loc.idx;

    // read-modify-write of the addressed byte
    assign cur_bit = rd_data[loc_reg.bit_sel];
    assign new_bit = ((item_reg.ink == INK_TOGGLE) ? !cur_bit : (item_reg.ink != INK_OFF))
                     ^ cfg_reg.invert_pixels;

    always_comb
    begin
        mod_byte                   = rd_data;
        mod_byte[loc_reg.bit_sel]  = new_bit;
    end

    assign byte_ok = ({2'b00, item_reg.byte_index} < 10'(STORE_BYTES));

    always_comb
    begin
        result = '0;
        case (item_reg.mode)
            MODE_DRAW:       result.written    = loc_reg.hit;
            MODE_READ_PIXEL: result.pixel_bit  = loc_reg.hit && cur_bit;
            MODE_READ_BYTE:  result.byte_value = byte_ok ? rd_data : 8'd0;
            default:         result = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WIPE:
                if (cursor_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_xfer)
                    state_next = (in_data.mode == MODE_CLEAR) ? ST_CLEAR : ST_ACCESS;
            ST_ACCESS:
                if (out_free)
                    state_next = ST_IDLE;
            ST_CLEAR:
                if (cursor_last)
                    state_next = ST_ACCESS;
            default:
                state_next = ST_WIPE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = cursor_reg;
        wr_data     = 8'd0;
        out_load    = 1'b0;
        cursor_next = cursor_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid;
            end
            ST_ACCESS:
            begin
                out_load = out_free;
                wr_en    = out_free && (item_reg.mode == MODE_DRAW) && loc_reg.hit;
                wr_addr  = loc_reg.idx;
                wr_data  = mod_byte;
            end
            ST_WIPE, ST_CLEAR:
            begin
                wr_en       = 1'b1;
                cursor_next = cursor_last ? '0 : cursor_reg + 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_ROTATION:     cfg_reg.rotation      <= cfg_data[1:0];
                    CFG_INVERT:       cfg_reg.invert_pixels <= cfg_data[0];
                    CFG_BOX_ORIGIN_X: cfg_reg.box_origin_x  <= cfg_data;
                    CFG_BOX_ORIGIN_Y: cfg_reg.box_origin_y  <= cfg_data;
                    CFG_BOX_WIDTH:    cfg_reg.box_width     <= cfg_data;
                    CFG_BOX_HEIGHT:   cfg_reg.box_height    <= cfg_data;
                    default:          cfg_reg               <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_data;
            loc_reg  <= loc;
        end
        if (out_load)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/fbpe_checker.sv
// ----------------------------------------------------------------------------
// fbpe_checker
// Port-level checks for the pixel engine, bound to the top level.
// ----------------------------------------------------------------------------
module fbpe_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input fbpe_pkg::pixel_in_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input fbpe_pkg::pixel_out_t out_data
);
    import fbpe_pkg::*;

    // a waiting result must not change under backpressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one item in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("transfer accepted during store access");

    // a clear occupies the store for longer than a single access does
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.mode == MODE_CLEAR |=> ##1 !in_ready)
        else $error("clear finished too early");

    // at most one result field is ever set
    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.written && (out_data.pixel_bit || out_data.byte_value != 8'd0))
                      && !(out_data.pixel_bit && out_data.byte_value != 8'd0))
        else $error("result mixes fields of two modes");

endmodule

bind mono_framebuffer_pixel_engine fbpe_checker u_fbpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
